/* hw/rtl/psle_pkg.sv */
// Shared types, codes and defaults for the page set with LRU-priority eject.
package psle_pkg;

  localparam int SET_ENTRIES_DEF = 16;

  // Request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_EJECT  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Entries of an eject may go stale once time + AGE_MARGIN < now
  localparam logic [32:0] AGE_MARGIN = 33'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch request, restart scan
    logic scan;    // issue one entry read
    logic decide;  // resolve request, update set, emit result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // read address is at the last entry
  } stat_t;

endpackage

/* hw/rtl/psle_ctrl.sv */
// Sequencing state machine for the page set: load, scan, drain, decide.
module psle_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output psle_pkg::cmd_t  cmd,
  input  psle_pkg::stat_t stat
);
  import psle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_DRAIN: begin
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* hw/rtl/psle_dp.sv */
// Datapath of the page set: entry storage, scan compare stage and decision.
module psle_dp #(
  parameter int SET_ENTRIES = psle_pkg::SET_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  psle_pkg::cmd_t  cmd,
  output psle_pkg::stat_t stat,
  input  logic [1:0]      kind,
  input  logic [31:0]     page_index,
  input  logic [31:0]     now_time,
  output logic            done,
  output logic [1:0]      status,
  output logic [31:0]     result_page
);
  import psle_pkg::*;

  localparam int AW = (SET_ENTRIES > 1) ? $clog2(SET_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(SET_ENTRIES - 1);

  logic [31:0] page_mem [SET_ENTRIES];
  logic [31:0] time_mem [SET_ENTRIES];
  logic [SET_ENTRIES-1:0] valid;

  // Latched request
  logic [1:0]  req_kind;
  logic [31:0] req_page;
  logic [31:0] req_now;

  // Scan read stage
  logic [AW-1:0] rd_addr;
  logic          cmp_en;
  logic [AW-1:0] cmp_slot;
  logic          rd_vld;
  logic [31:0]   rd_page;
  logic [31:0]   rd_time;

  // Scan trackers
  logic          found;
  logic [AW-1:0] hit_slot;
  logic          free_found;
  logic [AW-1:0] free_slot;
  logic          any;
  logic [31:0]   lru_time;
  logic [31:0]   lru_page;
  logic [AW-1:0] lru_slot;
  logic [31:0]   big_page;
  logic [AW-1:0] big_slot;

  // Decision
  logic          stale;
  logic [1:0]    dec_status;
  logic [31:0]   dec_page;
  logic [AW-1:0] wr_addr;
  logic          page_we;
  logic          time_we;
  logic          set_v;
  logic          clr_v;

  assign stat.scan_last = (rd_addr == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= kind;
      req_page <= page_index;
      req_now  <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      cmp_en  <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.load) begin
        rd_addr <= '0;
      end else if (cmd.scan && !stat.scan_last) begin
        rd_addr <= rd_addr + 1'b1;
      end
    end
  end

  // Registered reads of one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_page  <= page_mem[rd_addr];
      rd_time  <= time_mem[rd_addr];
      rd_vld   <= valid[rd_addr];
      cmp_slot <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (page_we) page_mem[wr_addr] <= req_page;
  end

  always_ff @(posedge clk) begin
    if (time_we) time_mem[wr_addr] <= req_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      any        <= 1'b0;
    end else if (cmd.load) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      any        <= 1'b0;
    end else if (cmp_en) begin
      if (rd_vld) begin
        any <= 1'b1;
        if (!found && rd_page == req_page) begin
          found    <= 1'b1;
          hit_slot <= cmp_slot;
        end
        // Oldest time wins, equal times go to the lower page index
        if (!any || rd_time < lru_time ||
            (rd_time == lru_time && rd_page < lru_page)) begin
          lru_time <= rd_time;
          lru_page <= rd_page;
          lru_slot <= cmp_slot;
        end
        if (!any || rd_page > big_page) begin
          big_page <= rd_page;
          big_slot <= cmp_slot;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_slot  <= cmp_slot;
      end
    end
  end

  assign stale = ({1'b0, lru_time} + AGE_MARGIN) < {1'b0, req_now};

  always_comb begin
    dec_status = ST_OK;
    dec_page   = '0;
    wr_addr    = hit_slot;
    page_we    = 1'b0;
    time_we    = 1'b0;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    case (req_kind)
      KIND_INSERT: begin
        if (found) begin
          time_we = cmd.decide;
        end else if (free_found) begin
          wr_addr = free_slot;
          page_we = cmd.decide;
          time_we = cmd.decide;
          set_v   = cmd.decide;
        end else begin
          dec_status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (found) begin
          clr_v = cmd.decide;
        end else begin
          dec_status = ST_MISS;
        end
      end
      KIND_SEARCH: begin
        if (found) begin
          time_we  = cmd.decide;
          dec_page = req_page;
        end else begin
          dec_status = ST_MISS;
        end
      end
      KIND_EJECT: begin
        if (!any) begin
          dec_status = ST_EMPTY;
        end else if (stale) begin
          wr_addr  = lru_slot;
          clr_v    = cmd.decide;
          dec_page = lru_page;
        end else if (req_page < big_page) begin
          wr_addr  = big_slot;
          clr_v    = cmd.decide;
          dec_page = big_page;
        end else begin
          dec_status = ST_MISS;
        end
      end
      default: begin
        dec_status = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (set_v) valid[wr_addr] <= 1'b1;
      if (clr_v) valid[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.decide;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      status      <= dec_status;
      result_page <= dec_page;
    end
  end

`ifndef SYNTHESIS
  a_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> !cmp_en)
    else $error("compare stage busy at decide");

  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (!found && !free_found))
    else $error("full reported with a usable slot");

  a_page_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (result_page == '0))
    else $error("result page set on a failing request");

  a_refresh_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && req_kind == KIND_INSERT && found)
      |=> ($countones(valid) == $past($countones(valid))))
    else $error("refresh changed the number of entries");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({set_v, clr_v}) &&
      (!(set_v || clr_v || page_we || time_we) || cmd.decide))
    else $error("set update outside decide");
`endif

endmodule

/* hw/rtl/page_set_lru_priority_evict.sv */
// Top level of the page set with LRU-priority eject: controller and datapath.
//
// A request (kind, page_index, now_time) is taken at a rising edge with start
// high and busy low. The block then reads its SET_ENTRIES entries one per
// cycle through the single read port of the entry store, drains the compare
// stage and decides, with busy high all the while, until the decision is
// made. The result (status, result_page) is shown for exactly one
// cycle with done high, in the cycle right after busy falls, and a new request
// may be taken in that same cycle. The receiver cannot stall: sample the
// result whenever done is high. Insert refreshes a present page, fills the
// lowest free entry or reports full; eject removes the oldest page if it is
// stale, else the largest page if it exceeds the incoming index.
module page_set_lru_priority_evict #(
  parameter int SET_ENTRIES = psle_pkg::SET_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] page_index,
  input  logic [31:0] now_time,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] result_page
);
  import psle_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  psle_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  psle_dp #(
    .SET_ENTRIES (SET_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (kind),
    .page_index  (page_index),
    .now_time    (now_time),
    .done        (done),
    .status      (status),
    .result_page (result_page)
  );

endmodule
